### src/lcdrr_pkg.sv
// ----------------------------------------------------------------------------
// lcdrr_pkg
// Shared types and constants for the page-mode LCD region refresh block.
// ----------------------------------------------------------------------------
package lcdrr_pkg;

    // default geometry of the frame store
    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // emit phase within one page
    localparam logic [1:0] PH_PAGE   = 2'd0;
    localparam logic [1:0] PH_COL_HI = 2'd1;
    localparam logic [1:0] PH_COL_LO = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    // controller command prefixes
    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;

    // configuration register indexes and reset values
    localparam logic REG_TOP_PAGE   = 1'b0;
    localparam logic REG_COL_OFFSET = 1'b1;
    localparam logic [3:0] TOP_PAGE_RST   = 4'd7;
    localparam logic [3:0] COL_OFFSET_RST = 4'd0;

    // controller to datapath
    typedef struct packed {
        logic clr_en;     // write one zero of the clearing sweep
        logic accept;     // an input request is taken this cycle
        logic load_data;  // RAM read data goes to the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;    // clearing sweep at its final entry
        logic step_data;   // request is a step that emits a data byte
        logic out_blocked; // output register full and stalled
    } dp_status_t;

endpackage

### src/page_lcd_region_refresh.sv
// ----------------------------------------------------------------------------
// page_lcd_region_refresh
// Page-organized frame store with a sequencer that refreshes a region of a
// page-addressed LCD controller: page, column-high, column-low, then data.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  in       | in_valid/in_stall, operation..store_data | request in
//  out      | out_valid/out_stall, lcd_byte,is_data,last| byte out
//  config   | APB psel/penable/pwrite/paddr/pwdata     | registers
//
// Write, start and command steps are taken at once; a data step also passes
// a read state for the registered read of the frame store, with in_stall high.
// After reset the store is cleared one entry a cycle, all COLUMNS*PAGES entries,
// with in_stall high; configuration writes are taken throughout.
// A stalled output holds off the next request until the byte is taken.
// ----------------------------------------------------------------------------
module page_lcd_region_refresh #(
    parameter int COLUMNS = lcdrr_pkg::COLUMNS_DEF,
    parameter int PAGES   = lcdrr_pkg::PAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic        full_screen,
    input  logic [6:0]  region_x,
    input  logic [5:0]  region_y,
    input  logic [7:0]  region_width,
    input  logic [6:0]  region_height,
    input  logic [9:0]  store_address,
    input  logic [7:0]  store_data,
    // byte channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  lcd_byte,
    output logic        is_data,
    output logic        last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcdrr_pkg::*;

    logic       cfg_wr;
    logic [3:0] top_page_reg;
    logic [3:0] col_offset_reg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_page_reg   <= TOP_PAGE_RST;
            col_offset_reg <= COL_OFFSET_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_TOP_PAGE)
            begin
                top_page_reg <= pwdata[3:0];
            end
            else
            begin
                col_offset_reg <= pwdata[3:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_COL_OFFSET) ? {28'd0, col_offset_reg}
                                                 : {28'd0, top_page_reg};

    lcdrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lcdrr_dp #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .top_page      (top_page_reg),
        .column_offset (col_offset_reg),
        .operation     (operation),
        .full_screen   (full_screen),
        .region_x      (region_x),
        .region_y      (region_y),
        .region_width  (region_width),
        .region_height (region_height),
        .store_address (store_address),
        .store_data    (store_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lcd_byte      (lcd_byte),
        .is_data       (is_data),
        .last          (last)
    );

endmodule

### src/lcdrr_ram.sv
// ----------------------------------------------------------------------------
// lcdrr_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lcdrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/lcdrr_ctrl.sv
// ----------------------------------------------------------------------------
// lcdrr_ctrl
// Sequencer: clearing sweep after reset, request intake, RAM read wait.
// ----------------------------------------------------------------------------
module lcdrr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  lcdrr_pkg::dp_status_t  status,
    output lcdrr_pkg::ctrl_cmd_t   cmd
);
    import lcdrr_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        in_stall      = 1'b1;
        cmd.clr_en    = 1'b0;
        cmd.accept    = 1'b0;
        cmd.load_data = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall   = status.out_blocked;
                cmd.accept = in_valid && !status.out_blocked;
                if (cmd.accept && status.step_data)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.load_data = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/lcdrr_dp.sv
// ----------------------------------------------------------------------------
// lcdrr_dp
// Datapath: region clipping, refresh counters, frame store, output register.
// ----------------------------------------------------------------------------
module lcdrr_dp #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcdrr_pkg::ctrl_cmd_t   cmd,
    output lcdrr_pkg::dp_status_t  status,
    input  logic [3:0]             top_page,
    input  logic [3:0]             column_offset,
    input  logic [1:0]             operation,
    input  logic                   full_screen,
    input  logic [6:0]             region_x,
    input  logic [5:0]             region_y,
    input  logic [7:0]             region_width,
    input  logic [6:0]             region_height,
    input  logic [9:0]             store_address,
    input  logic [7:0]             store_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             lcd_byte,
    output logic                   is_data,
    output logic                   last
);
    import lcdrr_pkg::*;

    localparam int STORE_SIZE = COLUMNS * PAGES;
    localparam int AW = $clog2(STORE_SIZE);
    localparam int CW = $clog2(COLUMNS + 1);
    localparam int SW = $clog2(COLUMNS);
    localparam int PW = $clog2(PAGES + 1);
    localparam logic [9:0] COLS10  = 10'(COLUMNS);
    localparam logic [5:0] PAGES6  = 6'(PAGES);

    // refresh state
    logic          busy_reg;
    logic [1:0]    phase_reg;
    logic [PW-1:0] page_reg;
    logic [PW-1:0] pages_left_reg;
    logic [AW-1:0] row_reg;
    logic [CW-1:0] bytes_left_reg;
    logic [SW-1:0] start_col_reg;
    logic [CW-1:0] width_reg;
    logic          last_pend_reg;
    logic [AW-1:0] clr_addr_reg;

    // output register
    logic          out_valid_reg;
    logic [7:0]    lcd_byte_reg;
    logic          is_data_reg;
    logic          last_reg;

    logic          op_write;
    logic          op_start;
    logic          op_step;
    logic          addr_ok;
    logic [9:0]    s_col;
    logic [9:0]    s_w;
    logic [9:0]    s_wc;
    logic [5:0]    s_pg;
    logic [5:0]    s_np;
    logic [5:0]    s_npc;
    logic          s_go;
    logic [CW-1:0] bl_dec;
    logic [PW-1:0] pl_dec;
    logic [3:0]    page4;
    logic [7:0]    col8;
    logic [7:0]    cmd_byte;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [7:0]    ram_rd_data;

    // request decode
    assign op_write = cmd.accept && (operation == OP_WRITE);
    assign op_start = cmd.accept && (operation == OP_START) && !busy_reg;
    assign op_step  = cmd.accept && (operation == OP_STEP) && busy_reg;
    assign addr_ok  = 32'(store_address) < STORE_SIZE;

    // region selection and clipping
    always_comb
    begin
        if (full_screen)
        begin
            s_col = 10'd0;
            s_w   = COLS10;
            s_pg  = 6'd0;
            s_np  = PAGES6;
        end
        else
        begin
            s_col = {3'b000, region_x};
            s_w   = {2'b00, region_width};
            s_pg  = {3'b000, region_y[5:3]};
            s_np  = {2'b00, region_height[6:3]};
        end
        if (s_col >= COLS10)
        begin
            s_wc = 10'd0;
        end
        else if (s_col + s_w > COLS10)
        begin
            s_wc = COLS10 - s_col;
        end
        else
        begin
            s_wc = s_w;
        end
        if (s_pg >= PAGES6)
        begin
            s_npc = 6'd0;
        end
        else if (s_pg + s_np > PAGES6)
        begin
            s_npc = PAGES6 - s_pg;
        end
        else
        begin
            s_npc = s_np;
        end
        s_go = (s_wc != 10'd0) && (s_npc != 6'd0);
    end

    // counters after a data byte
    assign bl_dec = bytes_left_reg - CW'(bytes_left_reg != '0);
    assign pl_dec = pages_left_reg - PW'(pages_left_reg != '0);

    // command bytes
    assign page4 = 4'(page_reg);
    assign col8  = 8'(start_col_reg) + {4'b0000, column_offset};
    always_comb
    begin
        case (phase_reg)
            PH_PAGE:   cmd_byte = CMD_PAGE | {4'b0000, top_page - page4};
            PH_COL_HI: cmd_byte = CMD_COL_HI | {4'b0000, col8[7:4]};
            default:   cmd_byte = {4'b0000, col8[3:0]};
        endcase
    end

    // refresh sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            phase_reg      <= PH_PAGE;
            page_reg       <= '0;
            pages_left_reg <= '0;
            row_reg        <= '0;
            bytes_left_reg <= '0;
            start_col_reg  <= '0;
            width_reg      <= '0;
            last_pend_reg  <= 1'b0;
        end
        else if (op_start && s_go)
        begin
            busy_reg       <= 1'b1;
            phase_reg      <= PH_PAGE;
            page_reg       <= PW'(s_pg);
            pages_left_reg <= PW'(s_npc);
            start_col_reg  <= SW'(s_col);
            width_reg      <= CW'(s_wc);
            bytes_left_reg <= CW'(s_wc);
            row_reg        <= AW'(16'(s_pg) * 16'(COLUMNS) + 16'(s_col));
        end
        else if (op_step)
        begin
            case (phase_reg)
                PH_PAGE:
                begin
                    phase_reg <= PH_COL_HI;
                end
                PH_COL_HI:
                begin
                    phase_reg <= PH_COL_LO;
                end
                PH_COL_LO:
                begin
                    phase_reg      <= PH_DATA;
                    bytes_left_reg <= width_reg;
                    row_reg <= AW'(16'(page_reg) * 16'(COLUMNS) + 16'(start_col_reg));
                end
                default:
                begin
                    row_reg        <= row_reg + AW'(1);
                    bytes_left_reg <= bl_dec;
                    last_pend_reg  <= (bl_dec == '0) && (pl_dec == '0);
                    if (bl_dec == '0)
                    begin
                        page_reg       <= page_reg + PW'(1);
                        pages_left_reg <= pl_dec;
                        phase_reg      <= PH_PAGE;
                        if (pl_dec == '0)
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    // clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // frame store ports
    assign ram_wr_en   = cmd.clr_en || (op_write && addr_ok);
    assign ram_wr_addr = cmd.clr_en ? clr_addr_reg : AW'(store_address);
    assign ram_wr_data = cmd.clr_en ? 8'h00 : store_data;
    assign ram_rd_en   = op_step && (phase_reg == PH_DATA);

    lcdrr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (row_reg),
        .rd_data (ram_rd_data)
    );

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_data || (op_step && phase_reg != PH_DATA))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_data)
        begin
            lcd_byte_reg <= ram_rd_data;
            is_data_reg  <= 1'b1;
            last_reg     <= last_pend_reg;
        end
        else if (op_step && phase_reg != PH_DATA)
        begin
            lcd_byte_reg <= cmd_byte;
            is_data_reg  <= 1'b0;
            last_reg     <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign lcd_byte  = lcd_byte_reg;
    assign is_data   = is_data_reg;
    assign last      = last_reg;

    // status to controller
    assign status.clr_last    = clr_addr_reg == AW'(STORE_SIZE - 1);
    assign status.step_data   = (operation == OP_STEP) && busy_reg && (phase_reg == PH_DATA);
    assign status.out_blocked = out_valid_reg && out_stall;

endmodule

### tb/page_lcd_region_refresh_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_lcd_region_refresh_tb
// Self-checking testbench for the page-mode LCD region refresh block. A
// shadow of the frame store and of the refresh sequencer predicts every
// LCD byte. Directed tests cover the reset-cleared store, region clipping,
// empty regions, busy-time requests and live register reads. Random traffic
// follows with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module page_lcd_region_refresh_tb;
    import lcdrr_pkg::*;

    localparam int COLUMNS      = COLUMNS_DEF;
    localparam int PAGES        = PAGES_DEF;
    localparam int STORE_SIZE   = COLUMNS * PAGES;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int IDLE_MAX     = 11;
    localparam int SETTLE       = 4;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASES       = 8;

    // code 3 is not a defined operation
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // register byte addresses
    localparam logic [2:0] ADDR_TOP_PAGE   = {REG_TOP_PAGE, 2'b00};
    localparam logic [2:0] ADDR_COL_OFFSET = {REG_COL_OFFSET, 2'b00};

    typedef struct packed {
        logic [1:0] operation;
        logic       full_screen;
        logic [6:0] region_x;
        logic [5:0] region_y;
        logic [7:0] region_width;
        logic [6:0] region_height;
        logic [9:0] store_address;
        logic [7:0] store_data;
    } lcd_request_t;

    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       last;
    } lcd_result_t;

    // clock, reset and block ports
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [1:0]  operation     = OP_WRITE;
    logic        full_screen   = 1'b0;
    logic [6:0]  region_x      = '0;
    logic [5:0]  region_y      = '0;
    logic [7:0]  region_width  = '0;
    logic [6:0]  region_height = '0;
    logic [9:0]  store_address = '0;
    logic [7:0]  store_data    = '0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [7:0]  lcd_byte;
    logic        is_data;
    logic        last;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the frame store and of the refresh sequencer
    logic [7:0] fs_mem [STORE_SIZE];
    logic       upd_busy;
    logic [1:0] upd_phase;
    logic [3:0] upd_page;
    logic [3:0] upd_pages_left;
    logic [9:0] upd_row;
    logic [7:0] upd_bytes_left;
    logic [7:0] upd_col;
    logic [7:0] upd_width;
    logic [3:0] cfg_top_page;
    logic [3:0] cfg_col_offset;

    lcd_result_t pending_bytes [$];
    lcd_result_t want;
    int          error_count   = 0;
    int          work_count    = 0;
    int          cycle_count   = 0;
    int          send_idle_max = IDLE_MAX;
    int          recv_idle_max = IDLE_MAX;
    int          stall_left    = 0;
    int          stall_draw;

    page_lcd_region_refresh u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .full_screen   (full_screen),
        .region_x      (region_x),
        .region_y      (region_y),
        .region_width  (region_width),
        .region_height (region_height),
        .store_address (store_address),
        .store_data    (store_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lcd_byte      (lcd_byte),
        .is_data       (is_data),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[page_lcd_region_refresh] ERROR");
            $finish;
        end
    end

    // receiver: random stall after every byte taken
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            stall_draw = (recv_idle_max == 0) ? 0 : $urandom_range(0, recv_idle_max);
            out_stall  <= (stall_draw != 0);
            stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
            out_stall <= 1'b0;
    end

    // byte checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, actual byte %h is_data %b last %b",
                         $time, lcd_byte, is_data, last);
                error_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (lcd_byte !== want.lcd_byte || is_data !== want.is_data
                    || last !== want.last)
                begin
                    $display("%0t: mismatch, expected byte %h is_data %b last %b, actual byte %h is_data %b last %b",
                             $time, want.lcd_byte, want.is_data, want.last,
                             lcd_byte, is_data, last);
                    error_count++;
                end
            end
        end
    end

    // Advance the shadow sequencer by one request; queue any LCD byte.
    // Returns 1 when the request has an effect.
    function automatic bit predict_refresh(input lcd_request_t rq);
        int          pg;
        int          np;
        int          col;
        int          w;
        logic [3:0]  pg_cmd;
        logic [7:0]  col_cmd;
        lcd_result_t res;
        bit          did;
        did = 1'b0;
        res = '0;
        case (rq.operation)
            OP_WRITE:
            begin
                fs_mem[rq.store_address] = rq.store_data;
                did = 1'b1;
            end
            OP_START:
            begin
                if (!upd_busy)
                begin
                    if (rq.full_screen)
                    begin
                        pg  = 0;
                        np  = PAGES;
                        col = 0;
                        w   = COLUMNS;
                    end
                    else
                    begin
                        pg  = int'(rq.region_y >> 3);
                        np  = int'(rq.region_height >> 3);
                        col = int'(rq.region_x);
                        w   = int'(rq.region_width);
                    end
                    // clip to the screen edge and to the last page
                    if (col >= COLUMNS)
                        w = 0;
                    else if (col + w > COLUMNS)
                        w = COLUMNS - col;
                    if (pg >= PAGES)
                        np = 0;
                    else if (pg + np > PAGES)
                        np = PAGES - pg;
                    if (w != 0 && np != 0)
                    begin
                        upd_busy       = 1'b1;
                        upd_phase      = PH_PAGE;
                        upd_page       = 4'(pg);
                        upd_pages_left = 4'(np);
                        upd_col        = 8'(col);
                        upd_width      = 8'(w);
                        upd_bytes_left = 8'(w);
                        upd_row        = 10'(pg * COLUMNS + col);
                        did            = 1'b1;
                    end
                end
            end
            OP_STEP:
            begin
                if (upd_busy)
                begin
                    // registers are read live at each command byte
                    col_cmd = upd_col + {4'h0, cfg_col_offset};
                    case (upd_phase)
                        PH_PAGE:
                        begin
                            pg_cmd       = cfg_top_page - upd_page;
                            res.lcd_byte = CMD_PAGE | {4'h0, pg_cmd};
                            upd_phase    = PH_COL_HI;
                        end
                        PH_COL_HI:
                        begin
                            res.lcd_byte = CMD_COL_HI | (col_cmd >> 4);
                            upd_phase    = PH_COL_LO;
                        end
                        PH_COL_LO:
                        begin
                            res.lcd_byte   = col_cmd & 8'h0F;
                            upd_phase      = PH_DATA;
                            upd_bytes_left = upd_width;
                            upd_row        = 10'(int'(upd_page) * COLUMNS + int'(upd_col));
                        end
                        default:
                        begin
                            res.is_data  = 1'b1;
                            res.lcd_byte = fs_mem[upd_row];
                            upd_row++;
                            if (upd_bytes_left != 0)
                                upd_bytes_left--;
                            if (upd_bytes_left == 0)
                            begin
                                upd_page++;
                                if (upd_pages_left != 0)
                                    upd_pages_left--;
                                if (upd_pages_left == 0)
                                begin
                                    res.last = 1'b1;
                                    upd_busy = 1'b0;
                                end
                                upd_phase = PH_PAGE;
                            end
                        end
                    endcase
                    pending_bytes.push_back(res);
                    did = 1'b1;
                end
            end
            default: ;
        endcase
        return did;
    endfunction

    // request with random filler in every field
    function automatic lcd_request_t random_request(input logic [1:0] op);
        logic [63:0]  bits;
        lcd_request_t rq;
        bits = {$urandom(), $urandom()};
        rq = bits[$bits(lcd_request_t)-1:0];
        rq.operation = op;
        return rq;
    endfunction

    // send one request after a random gap; valid stays high with no gap
    task automatic send_request(input lcd_request_t rq);
        int gap;
        gap = (send_idle_max == 0) ? 0 : $urandom_range(0, send_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= rq.operation;
        full_screen   <= rq.full_screen;
        region_x      <= rq.region_x;
        region_y      <= rq.region_y;
        region_width  <= rq.region_width;
        region_height <= rq.region_height;
        store_address <= rq.store_address;
        store_data    <= rq.store_data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        void'(predict_refresh(rq));
        work_count++;
    endtask

    task automatic send_write(input logic [9:0] addr, input logic [7:0] data);
        lcd_request_t rq;
        rq = random_request(OP_WRITE);
        rq.store_address = addr;
        rq.store_data    = data;
        send_request(rq);
    endtask

    task automatic send_start(input logic fs, input logic [6:0] x, input logic [5:0] y,
                              input logic [7:0] w, input logic [6:0] h);
        lcd_request_t rq;
        rq = random_request(OP_START);
        rq.full_screen   = fs;
        rq.region_x      = x;
        rq.region_y      = y;
        rq.region_width  = w;
        rq.region_height = h;
        send_request(rq);
    endtask

    task automatic send_steps(input int n);
        repeat (n) send_request(random_request(OP_STEP));
    endtask

    // hold requests until every queued byte is out, then let the block settle
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write: setup then access; taken at the edge with pready high
    task automatic write_register(input logic [2:0] addr, input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {28'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TOP_PAGE)
            cfg_top_page = value;
        else
            cfg_col_offset = value;
    endtask

    // cleared store and written bytes at the store extremes, reset registers
    task automatic test_clear_and_write();
        send_write(10'd1023, 8'hA5);
        send_write(10'd0, 8'hFF);
        send_start(1'b0, 7'd126, 6'd63, 8'd2, 7'd8);
        send_steps(5);
    endtask

    // width and page clipping, empty regions, idle step, unused code
    task automatic test_region_clipping();
        send_start(1'b0, 7'd127, 6'd56, 8'd255, 7'd127);
        send_steps(4);
        send_start(1'b0, 7'd5, 6'd0, 8'd0, 7'd64);
        send_start(1'b0, 7'd5, 6'd0, 8'd10, 7'd7);
        send_steps(1);
        send_request(random_request(OP_UNUSED));
    endtask

    // start ignored while busy, write while busy shows in later data
    task automatic test_busy_rules();
        send_start(1'b0, 7'd0, 6'd0, 8'd2, 7'd8);
        send_steps(1);
        send_start(1'b1, 7'd0, 6'd0, 8'd0, 7'd0);
        send_write(10'd1, 8'h3C);
        send_steps(4);
    endtask

    // register extremes, page number wrap, live register reads mid-refresh
    task automatic test_register_update();
        wait_for_results();
        write_register(ADDR_TOP_PAGE, 4'd0);
        write_register(ADDR_COL_OFFSET, 4'd15);
        send_start(1'b0, 7'd127, 6'd8, 8'd1, 7'd8);
        send_steps(4);
        send_start(1'b0, 7'd3, 6'd16, 8'd1, 7'd8);
        send_steps(1);
        wait_for_results();
        write_register(ADDR_TOP_PAGE, 4'd15);
        write_register(ADDR_COL_OFFSET, 4'd0);
        send_steps(3);
    endtask

    // one refresh: writes, some near the region, a start, then mostly steps to the end
    task automatic random_refresh_sequence(input logic force_full);
        lcd_request_t rq;
        lcd_request_t start_rq;
        int           n_writes;
        send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        start_rq = random_request(OP_START);
        start_rq.full_screen   = force_full;
        start_rq.region_x      = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(112, 127))
                                                             : 7'($urandom_range(0, 127));
        start_rq.region_width  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                             : 8'($urandom_range(0, 12));
        start_rq.region_height = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(0, 127))
                                                              : 7'($urandom_range(0, 23));
        n_writes = $urandom_range(0, 3);
        repeat (n_writes)
        begin
            rq = random_request(OP_WRITE);
            if ($urandom_range(0, 1) == 0)
                rq.store_address = {start_rq.region_y[5:3], start_rq.region_x}
                                   + 10'($urandom_range(0, 15));
            send_request(rq);
        end
        send_request(start_rq);
        while (upd_busy)
        begin
            case ($urandom_range(0, 19))
                0:       rq = random_request(OP_WRITE);
                1:       rq = random_request(OP_START);
                2:       rq = random_request(OP_UNUSED);
                default: rq = random_request(OP_STEP);
            endcase
            send_request(rq);
        end
    endtask

    // phases of random traffic, each under its own register setting
    task automatic test_random_traffic();
        int         target;
        int         noise_op;
        logic [3:0] tp;
        logic [3:0] co;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_for_results();
            if (ph == 0)
            begin
                tp = 4'd15;
                co = 4'd15;
            end
            else if (ph == 1)
            begin
                tp = 4'd0;
                co = 4'd0;
            end
            else
            begin
                tp = 4'($urandom_range(0, 15));
                co = 4'($urandom_range(0, 15));
            end
            write_register(ADDR_TOP_PAGE, tp);
            write_register(ADDR_COL_OFFSET, co);
            if (ph == 3)
                random_refresh_sequence(1'b1);
            target = work_count + RANDOM_ITEMS / PHASES;
            while (work_count < target)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // loose request between refreshes
                    noise_op = $urandom_range(0, 2);
                    if (noise_op == 0)
                        send_request(random_request(OP_WRITE));
                    else if (noise_op == 1)
                        send_request(random_request(OP_STEP));
                    else
                        send_request(random_request(OP_UNUSED));
                end
                else
                    random_refresh_sequence(1'b0);
            end
        end
    endtask

    // main sequence
    initial
    begin
        for (int i = 0; i < STORE_SIZE; i++)
            fs_mem[i] = 8'h00;
        upd_busy       = 1'b0;
        upd_phase      = PH_PAGE;
        upd_page       = '0;
        upd_pages_left = '0;
        upd_row        = '0;
        upd_bytes_left = '0;
        upd_col        = '0;
        upd_width      = '0;
        cfg_top_page   = TOP_PAGE_RST;
        cfg_col_offset = COL_OFFSET_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_clear_and_write();
        test_region_clipping();
        test_busy_rules();
        test_register_update();
        test_random_traffic();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_bytes.size() == 0)
            $display("[page_lcd_region_refresh] OK");
        else
            $display("[page_lcd_region_refresh] ERROR");
        $finish;
    end

endmodule

### files.f
src/lcdrr_pkg.sv
src/lcdrr_ram.sv
src/lcdrr_ctrl.sv
src/lcdrr_dp.sv
src/page_lcd_region_refresh.sv
tb/page_lcd_region_refresh_tb.sv
